// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Each use states one property on clk, held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gcb_pkg.sv =====
package gcb_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_PLACE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_RUN,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [16:0] coord_x;
    logic [16:0] coord_y;
    logic [16:0] coord_z;
    logic [11:0] cell_select;
  } req_t;

  typedef struct packed {
    logic [11:0] cell_id;
    logic [19:0] slot;
    logic [20:0] cell_count;
    logic        saturated;
  } rsp_t;

  typedef struct packed {
    logic adv;
    logic sweep;
  } ctl_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [11:0] id;
    logic        sel_ok;
  } loc_t;

  typedef struct packed {
    logic valid;
    logic clear;
  } stat_t;

  localparam logic [3:0]  REG_CELLS_PER_DIM = 4'd0;
  localparam logic [3:0]  REG_EPSILON       = 4'd1;
  localparam logic [4:0]  CELLS_PER_DIM_RST = 5'd4;
  localparam logic [7:0]  EPSILON_RST       = 8'd1;
  localparam logic [16:0] ONE_FIXED         = 17'h10000;
  localparam int          FRAC_BITS         = 16;

endpackage

// ===== rtl/gcb_locate.sv =====
module gcb_locate import gcb_pkg::*; #(
  parameter int AX_W   = 4,
  parameter int PW     = 5,
  parameter int PSQ_W  = 10,
  parameter int ADDR_W = 12,
  parameter int DEPTH  = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  input  logic              take,
  input  req_t              req,
  input  logic [PW-1:0]     p_eff,
  input  logic [PSQ_W-1:0]  p_sq,
  input  logic [7:0]        epsilon,
  output loc_t              loc,
  output logic [ADDR_W-1:0] addr
);

  localparam int PROD_W = 17 + PW + 1;
  localparam int T_W    = PROD_W - FRAC_BITS;

  logic              b_valid;
  kind_t             b_kind;
  logic [AX_W-1:0]   b_x;
  logic [AX_W-1:0]   b_y;
  logic [AX_W-1:0]   b_z;
  logic [11:0]       b_sel;
  logic [ADDR_W-1:0] pt_addr;

  function automatic logic [AX_W-1:0] axis_cell(input logic [16:0] coord,
                                                input logic [PW-1:0] p,
                                                input logic [7:0]    eps);
    logic [16:0]       c;
    logic [PROD_W-1:0] prod;
    logic [T_W-1:0]    t;
    c    = (coord > ONE_FIXED) ? ONE_FIXED : coord;
    c    = c + 17'(eps);
    prod = PROD_W'(c) * PROD_W'(p) + PROD_W'(eps);
    t    = prod[PROD_W-1:FRAC_BITS];
    if (t >= T_W'(p)) begin
      t = T_W'(p) - T_W'(1);
    end
    return AX_W'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (ctl.adv) begin
      b_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && take) begin
      b_kind <= req.kind;
      b_x    <= axis_cell(req.coord_x, p_eff, epsilon);
      b_y    <= axis_cell(req.coord_y, p_eff, epsilon);
      b_z    <= axis_cell(req.coord_z, p_eff, epsilon);
      b_sel  <= req.cell_select;
    end
  end

  assign pt_addr = ADDR_W'(ADDR_W'(b_z) * ADDR_W'(p_sq) + ADDR_W'(b_y) * ADDR_W'(p_eff)
                   + ADDR_W'(b_x));

  always_comb begin
    loc.valid  = b_valid;
    loc.kind   = b_kind;
    loc.sel_ok = (32'(b_sel) < DEPTH);
    if (b_kind == KIND_READ) begin
      addr   = ADDR_W'(b_sel);
      loc.id = b_sel;
    end else begin
      addr   = pt_addr;
      loc.id = 12'(pt_addr);
    end
  end

endmodule

// ===== rtl/gcb_store.sv =====
module gcb_store import gcb_pkg::*; #(
  parameter int ADDR_W         = 12,
  parameter int DEPTH          = 4096,
  parameter int CNT_W          = 21,
  parameter int POINT_CAPACITY = 1048576
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  input  logic [ADDR_W-1:0] sweep_idx,
  input  loc_t              loc,
  input  logic [ADDR_W-1:0] addr,
  output stat_t             stat,
  output rsp_t              result
);

  localparam int               WORD_W   = 2 * CNT_W;
  localparam logic [CNT_W-1:0] CAP      = CNT_W'(POINT_CAPACITY);
  localparam logic [19:0]      SLOT_TOP = 20'(POINT_CAPACITY - 1);

  logic [WORD_W-1:0] mem [DEPTH];

  logic              c_valid;
  kind_t             c_kind;
  logic [ADDR_W-1:0] c_addr;
  logic [11:0]       c_id;
  logic              c_sel_ok;
  logic [WORD_W-1:0] rd_word;
  logic              fwd_hit;
  logic [WORD_W-1:0] fwd_word;

  logic [WORD_W-1:0] cur;
  logic [CNT_W-1:0]  cnt_old;
  logic [CNT_W-1:0]  fill_old;
  logic [CNT_W-1:0]  cnt_new;
  logic [CNT_W-1:0]  fill_new;
  logic              wr_en;
  logic [WORD_W-1:0] wr_word;

  always_ff @(posedge clk) begin
    if (ctl.sweep) begin
      mem[sweep_idx] <= '0;
    end else if (wr_en) begin
      mem[c_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && loc.valid) begin
      rd_word <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (ctl.adv) begin
      c_valid <= loc.valid;
      fwd_hit <= wr_en && (c_addr == addr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      c_kind   <= loc.kind;
      c_addr   <= addr;
      c_id     <= loc.id;
      c_sel_ok <= loc.sel_ok;
      fwd_word <= wr_word;
    end
  end

  always_comb begin
    cur      = fwd_hit ? fwd_word : rd_word;
    cnt_old  = cur[WORD_W-1:CNT_W];
    fill_old = cur[CNT_W-1:0];
    cnt_new  = cnt_old;
    fill_new = fill_old;
    result   = '0;
    case (c_kind)
      KIND_COUNT: begin
        result.cell_id = c_id;
        if (cnt_old >= CAP) begin
          result.saturated = 1'b1;
        end else begin
          cnt_new = cnt_old + CNT_W'(1);
        end
        result.cell_count = 21'(cnt_new);
      end
      KIND_PLACE: begin
        result.cell_id = c_id;
        if (fill_old >= CAP) begin
          result.saturated = 1'b1;
          result.slot      = SLOT_TOP;
        end else begin
          result.slot = 20'(fill_old);
          fill_new    = fill_old + CNT_W'(1);
        end
        result.cell_count = 21'(cnt_old);
      end
      KIND_READ: begin
        result.cell_id = c_id;
        if (c_sel_ok) begin
          result.cell_count = 21'(cnt_old);
        end
      end
      default: begin
        result = '0;
      end
    endcase
    wr_word    = {cnt_new, fill_new};
    wr_en      = ctl.adv && c_valid && (c_kind == KIND_COUNT || c_kind == KIND_PLACE);
    stat.valid = c_valid;
    stat.clear = (c_kind == KIND_CLEAR);
  end

endmodule

// ===== rtl/grid_cell_binning_3d.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_t: kind, coordinates, cell_select
// rsp       out        rsp_valid/rsp_ready   rsp_t: cell_id, slot, cell_count, saturated
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// An accepted item passes the locate, store read and result registers; one item per cycle
// is accepted while the result register drains, and the rate is set by the single read
// port and single write port of the cell store, with a forwarding path between neighboring
// items. A clear item sweeps all MAX_CELLS_PER_DIM**3 store entries (4096 by default) one
// entry per cycle, and no item is accepted until it leaves. After reset the same sweep runs
// before the first item is taken; configuration writes are taken at all times.
module grid_cell_binning_3d import gcb_pkg::*; #(
  parameter int MAX_CELLS_PER_DIM = 16,
  parameter int POINT_CAPACITY    = 1048576
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int DEPTH  = MAX_CELLS_PER_DIM ** 3;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AX_W   = (MAX_CELLS_PER_DIM > 1) ? $clog2(MAX_CELLS_PER_DIM) : 1;
  localparam int PW     = $clog2(MAX_CELLS_PER_DIM + 1);
  localparam int PSQ_W  = 2 * PW;
  localparam int CNT_W  = $clog2(POINT_CAPACITY + 1);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);

  logic [4:0]        cells_per_dim;
  logic [7:0]        epsilon;
  logic [PW-1:0]     p_eff;
  logic [PSQ_W-1:0]  p_sq;
  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] sweep_idx;
  logic [ADDR_W-1:0] sweep_idx_next;
  logic              clear_pending;
  logic              take;
  ctl_t              ctl;
  loc_t              loc;
  logic [ADDR_W-1:0] addr;
  stat_t             stat;
  rsp_t              result;
  logic              sweeping;
  logic              clear_at_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_dim <= CELLS_PER_DIM_RST;
      epsilon       <= EPSILON_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CELLS_PER_DIM) begin
        cells_per_dim <= cfg_data[4:0];
      end else if (cfg_index == REG_EPSILON) begin
        epsilon <= cfg_data;
      end
    end
  end

  always_comb begin
    if (cells_per_dim == 5'd0) begin
      p_eff = PW'(1);
    end else if (32'(cells_per_dim) > MAX_CELLS_PER_DIM) begin
      p_eff = PW'(MAX_CELLS_PER_DIM);
    end else begin
      p_eff = PW'(cells_per_dim);
    end
  end

  always_ff @(posedge clk) begin
    p_sq <= PSQ_W'(p_eff) * PSQ_W'(p_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep_idx <= '0;
    end else begin
      state     <= state_next;
      sweep_idx <= sweep_idx_next;
    end
  end

  always_comb begin
    sweeping       = (state == ST_INIT) || (state == ST_SWEEP);
    clear_at_c     = stat.valid && stat.clear;
    ctl.sweep      = sweeping;
    ctl.adv        = (!rsp_valid || rsp_ready) && !sweeping
                     && (!clear_at_c || state == ST_DONE);
    req_ready      = ctl.adv && (state == ST_RUN) && !clear_pending;
    take           = req_valid && req_ready;
    state_next     = state;
    sweep_idx_next = '0;
    case (state)
      ST_INIT, ST_SWEEP: begin
        if (sweep_idx == LAST_IDX) begin
          state_next = (state == ST_INIT) ? ST_RUN : ST_DONE;
        end else begin
          sweep_idx_next = sweep_idx + ADDR_W'(1);
        end
      end
      ST_RUN: begin
        if (clear_at_c) begin
          state_next = ST_SWEEP;
        end
      end
      ST_DONE: begin
        if (ctl.adv) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_pending <= 1'b0;
    end else if (take && req.kind == KIND_CLEAR) begin
      clear_pending <= 1'b1;
    end else if (state == ST_DONE && ctl.adv) begin
      clear_pending <= 1'b0;
    end
  end

  gcb_locate #(
    .AX_W   (AX_W),
    .PW     (PW),
    .PSQ_W  (PSQ_W),
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_locate (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .take    (take),
    .req     (req),
    .p_eff   (p_eff),
    .p_sq    (p_sq),
    .epsilon (epsilon),
    .loc     (loc),
    .addr    (addr)
  );

  gcb_store #(
    .ADDR_W         (ADDR_W),
    .DEPTH          (DEPTH),
    .CNT_W          (CNT_W),
    .POINT_CAPACITY (POINT_CAPACITY)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sweep_idx (sweep_idx),
    .loc       (loc),
    .addr      (addr),
    .stat      (stat),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.adv) begin
      rsp_valid <= stat.valid;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && stat.valid) begin
      rsp <= result;
    end
  end

`include "assert_macros.svh"

  `ASSERT_SAME(a_no_take_in_sweep, state == ST_INIT || state == ST_SWEEP, !req_ready, "item taken during store sweep")
  `ASSERT_NEXT(a_sweep_steps, state == ST_SWEEP && sweep_idx != LAST_IDX, sweep_idx == ADDR_W'($past(sweep_idx) + ADDR_W'(1)), "sweep index skipped")
  `ASSERT_NEXT(a_clear_result, ctl.adv && stat.valid && stat.clear, rsp_valid && rsp.cell_count == 21'd0 && !rsp.saturated, "clear item gave nonzero result")
  `ASSERT_SAME(a_clear_blocks, clear_pending, !req_ready, "item taken behind a pending clear")

endmodule

// ===== sim/tb_grid_cell_binning_3d.sv =====
module tb_grid_cell_binning_3d;
  timeunit 1ns;
  timeprecision 1ps;

  import gcb_pkg::*;

  localparam int          MAX_DIM     = 16;
  localparam int          CAPACITY    = 1048576;
  localparam int          STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int          CLK_PERIOD  = 4;
  localparam int          HOLD_AFTER  = 300;
  localparam int          HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 600000;

  class binning_scoreboard;
    logic [20:0] counts_m [STORE_DEPTH];
    logic [20:0] fills_m [STORE_DEPTH];
    logic [4:0]  dim_reg;
    logic [7:0]  eps_reg;
    rsp_t        due_results [$];
    int          errors;
    int          checked;

    function new();
      dim_reg = CELLS_PER_DIM_RST;
      eps_reg = EPSILON_RST;
      errors  = 0;
      checked = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (counts_m[i]) begin
        counts_m[i] = '0;
        fills_m[i]  = '0;
      end
    endfunction

    function int unsigned grid();
      int unsigned p;
      p = dim_reg;
      if (p == 0) p = 1;
      if (p > MAX_DIM) p = MAX_DIM;
      return p;
    endfunction

    function int unsigned axis_bin(logic [16:0] coord, int unsigned p);
      int unsigned c;
      int unsigned t;
      c = coord;
      if (c > ONE_FIXED) c = ONE_FIXED;
      t = ((c + eps_reg) * p + eps_reg) >> FRAC_BITS;
      if (t >= p) t = p - 1;
      return t;
    endfunction

    function int unsigned cell_of(req_t r);
      int unsigned p;
      p = grid();
      return (axis_bin(r.coord_z, p) * p + axis_bin(r.coord_y, p)) * p +
             axis_bin(r.coord_x, p);
    endfunction

    function void set_register(logic [3:0] idx, logic [7:0] data);
      case (idx)
        REG_CELLS_PER_DIM: dim_reg = data[4:0];
        REG_EPSILON:       eps_reg = data;
        default: ;
      endcase
    endfunction

    function void note_request(req_t r);
      rsp_t        exp;
      int unsigned c;
      exp = '0;
      case (r.kind)
        KIND_CLEAR: wipe();
        KIND_COUNT: begin
          c = cell_of(r);
          exp.cell_id = c[11:0];
          if (counts_m[c] >= CAPACITY) exp.saturated = 1'b1;
          else counts_m[c] = counts_m[c] + 1'b1;
          exp.cell_count = counts_m[c];
        end
        KIND_PLACE: begin
          c = cell_of(r);
          exp.cell_id = c[11:0];
          if (fills_m[c] >= CAPACITY) begin
            exp.saturated = 1'b1;
            exp.slot      = 20'(CAPACITY - 1);
          end else begin
            exp.slot   = fills_m[c][19:0];
            fills_m[c] = fills_m[c] + 1'b1;
          end
          exp.cell_count = counts_m[c];
        end
        default: begin
          exp.cell_id = r.cell_select;
          if (r.cell_select < STORE_DEPTH) exp.cell_count = counts_m[r.cell_select];
        end
      endcase
      due_results.push_back(exp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (due_results.size() == 0) begin
        $error("result with no item pending: cell_id %0d", got.cell_id);
        errors++;
        return;
      end
      exp = due_results.pop_front();
      checked++;
      if (got.cell_id !== exp.cell_id) begin
        $error("cell_id expected %0d actual %0d", exp.cell_id, got.cell_id);
        errors++;
      end
      if (got.slot !== exp.slot) begin
        $error("slot expected %0d actual %0d", exp.slot, got.slot);
        errors++;
      end
      if (got.cell_count !== exp.cell_count) begin
        $error("cell_count expected %0d actual %0d", exp.cell_count, got.cell_count);
        errors++;
      end
      if (got.saturated !== exp.saturated) begin
        $error("saturated expected %0d actual %0d", exp.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req       = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  binning_scoreboard sb;
  int unsigned       items_sent = 0;
  int unsigned       tx_idle    = 10;
  int unsigned       rx_idle    = 50;
  int unsigned       cycles     = 0;
  bit                held       = 1'b0;

  grid_cell_binning_3d #(
    .MAX_CELLS_PER_DIM(MAX_DIM),
    .POINT_CAPACITY   (CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic req_t make_req(kind_t k, logic [16:0] x, logic [16:0] y,
                                    logic [16:0] z, logic [11:0] sel);
    req_t r;
    r.kind        = k;
    r.coord_x     = x;
    r.coord_y     = y;
    r.coord_z     = z;
    r.cell_select = sel;
    return r;
  endfunction

  // Part of the coordinates fall on or near cell borders so that the rounding tolerance decides the bin.
  function automatic logic [16:0] pick_coord(int unsigned p);
    int unsigned cut;
    case ($urandom_range(9))
      0: return 17'd0;
      1: return ONE_FIXED;
      2: return 17'($urandom_range(131071));
      3, 4: begin
        cut = ($urandom_range(p) * 65536) / p + $urandom_range(4);
        if (cut >= 2) cut = cut - 2;
        return 17'(cut);
      end
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic send_item(input req_t item);
    if ($urandom_range(99) < tx_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_regs(input logic [7:0] dim, input logic [7:0] eps);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CELLS_PER_DIM;
    cfg_data  <= dim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_EPSILON;
    cfg_data  <= eps;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // An optional clear, a counting pass over a set of points, then a placing pass over the same
  // points in reverse order, then reads of cells they landed in and one read of a random cell.
  task automatic point_sequence();
    req_t        pts [$];
    req_t        pt;
    int          n;
    int unsigned p;
    p = sb.grid();
    n = $urandom_range(16, 3);
    if ($urandom_range(9) == 0)
      send_item(make_req(KIND_CLEAR, 17'($urandom), 17'($urandom), 17'($urandom),
                         12'($urandom)));
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(2) == 0) pt = pts[$urandom_range(i - 1)];
      else pt = make_req(KIND_COUNT, pick_coord(p), pick_coord(p), pick_coord(p),
                         12'($urandom));
      pts.push_back(pt);
    end
    foreach (pts[i]) send_item(pts[i]);
    for (int i = n - 1; i >= 0; i--) begin
      pt      = pts[i];
      pt.kind = KIND_PLACE;
      send_item(pt);
    end
    repeat ($urandom_range(3)) begin
      pt             = pts[$urandom_range(n - 1)];
      pt.kind        = KIND_READ;
      pt.cell_select = 12'(sb.cell_of(pt));
      send_item(pt);
    end
    send_item(make_req(KIND_READ, 17'($urandom), 17'($urandom), 17'($urandom),
                       12'($urandom)));
  endtask

  task automatic noise_item();
    kind_t k;
    k = kind_t'($urandom_range(3));
    if (k == KIND_CLEAR && $urandom_range(3) != 0) k = KIND_READ;
    send_item(make_req(k, 17'($urandom), 17'($urandom), 17'($urandom), 12'($urandom)));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
    end
  end

  // Once, the receiver stops for a long stretch so that the block backs up onto its input.
  initial begin
    forever begin
      @(posedge clk);
      if (!held && sb != null && sb.checked >= HOLD_AFTER) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      rsp_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  dims [6];
    logic [7:0]  epss [6];
    int unsigned target;
    dims = '{8'd16, 8'd0, 8'hFF, 8'd5, 8'd1, 8'hE3};
    epss = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd255, 8'd37};
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_regs(8'd4, 8'd1);

    send_item(make_req(KIND_READ, 17'd0, 17'd0, 17'd0, 12'd0));
    send_item(make_req(KIND_COUNT, 17'd0, 17'd0, 17'd0, 12'd0));
    send_item(make_req(KIND_COUNT, ONE_FIXED, ONE_FIXED, ONE_FIXED, 12'hFFF));
    send_item(make_req(KIND_COUNT, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 12'd0));
    send_item(make_req(KIND_COUNT, 17'd16383, 17'd16384, 17'd49151, 12'd0));
    send_item(make_req(KIND_COUNT, 17'h10001, 17'd0, 17'd32768, 12'd0));
    send_item(make_req(KIND_PLACE, 17'd0, 17'd0, 17'd0, 12'hFFF));
    send_item(make_req(KIND_PLACE, 17'd0, 17'd0, 17'd0, 12'd0));
    send_item(make_req(KIND_PLACE, ONE_FIXED, ONE_FIXED, ONE_FIXED, 12'd0));
    send_item(make_req(KIND_PLACE, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 12'd0));
    send_item(make_req(KIND_PLACE, 17'd16383, 17'd16384, 17'd49151, 12'd0));
    send_item(make_req(KIND_READ, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 12'd63));
    send_item(make_req(KIND_READ, 17'd0, 17'd0, 17'd0, 12'd53));
    send_item(make_req(KIND_READ, 17'd0, 17'd0, 17'd0, 12'hFFF));
    send_item(make_req(KIND_READ, 17'd0, 17'd0, 17'd0, 12'd0));
    send_item(make_req(KIND_CLEAR, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 12'hFFF));
    send_item(make_req(KIND_READ, 17'd0, 17'd0, 17'd0, 12'd0));
    send_item(make_req(KIND_READ, 17'd0, 17'd0, 17'd0, 12'd63));
    send_item(make_req(KIND_PLACE, 17'd0, 17'd0, 17'd0, 12'd0));
    send_item(make_req(KIND_COUNT, 17'd0, 17'd0, 17'd0, 12'd0));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        tx_idle = 10;
        rx_idle = 50;
      end else if (ph < 4) begin
        tx_idle = 50;
        rx_idle = 10;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      write_regs(dims[ph], epss[ph]);
      target = items_sent + 150;
      while (items_sent < target) begin
        if ($urandom_range(4) == 0) noise_item();
        else point_sequence();
      end
      settle();
    end

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
